// ----- hw/rtl/texel_block_palette_matcher_defines.svh -----
// Assertion macros shared by the checker
`ifndef TEXEL_BLOCK_PALETTE_MATCHER_DEFINES_SVH
`define TEXEL_BLOCK_PALETTE_MATCHER_DEFINES_SVH
`define TBPM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define TBPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- hw/rtl/tbpm_pkg.sv -----
package tbpm_pkg;
    localparam int PALETTE_DEPTH = 8192;
    localparam int PAL_AW = $clog2(PALETTE_DEPTH);
    localparam int CNT_W = PAL_AW + 1;
    localparam logic [1:0] MODE_FOUR = 2'd2;
    localparam logic [1:0] MODE_BLEND = 2'd3;
    localparam logic [0:0] REG_MATCH_TOL = 1'b0;
    localparam logic [0:0] REG_BLEND_TOL = 1'b1;

    function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
        absdiff8 = (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [7:0] worst_diff(input logic [23:0] a, input logic [23:0] b);
        logic [7:0] d0, d1, d2, m;
        d0 = absdiff8(a[7:0], b[7:0]);
        d1 = absdiff8(a[15:8], b[15:8]);
        d2 = absdiff8(a[23:16], b[23:16]);
        m = (d0 > d1) ? d0 : d1;
        worst_diff = (m > d2) ? m : d2;
    endfunction
endpackage

// ----- hw/rtl/tbpm_lane.sv -----
// One comparison lane: worst channel difference between a stored entry and a tile color
module tbpm_lane (
    input  logic        i_clk,
    input  logic [23:0] i_entry,
    input  logic [23:0] i_color,
    output logic [7:0]  o_diff
);
    logic [7:0] r_diff;
    always_ff @(posedge i_clk) begin
        r_diff <= tbpm_pkg::worst_diff(i_entry, i_color);
    end
    assign o_diff = r_diff;
endmodule

// ----- hw/rtl/texel_block_palette_matcher.sv -----
// The scan length follows palette_count as taken before the tile
// (one even base per scan cycle).
// One tile at a time: o_ready is low from acceptance until the output transaction.
// The scan reads the palette at four banks, one entry per lane per cycle.
// Reset (i_rst_n low, synchronous) empties the palette and restores
// match_tolerance 8, blend_tolerance 16; palette contents are not cleared.
module texel_block_palette_matcher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [23:0] i_color_zero,
    input  logic [23:0] i_color_one,
    input  logic [23:0] i_color_two,
    input  logic [23:0] i_color_three,
    input  logic [2:0]  i_used_colors,
    input  logic [31:0] i_texel_indices,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_block_header,
    output logic [31:0] o_texel_rows,
    output logic [15:0] o_palette_used,
    output logic        o_palette_overflow
);
    localparam int AW = tbpm_pkg::PAL_AW;
    localparam int CW = tbpm_pkg::CNT_W;
    localparam int BD = tbpm_pkg::PALETTE_DEPTH / 4;

    typedef enum logic [2:0] {S_IDLE, S_BLEND, S_SCAN, S_DRAIN, S_DECIDE, S_WRITE, S_OUT} t_state;

    t_state r_state;
    logic [7:0] r_match_tol, r_blend_tol;
    logic [23:0] r_col [4];
    logic r_four;
    logic [1:0] r_mode;
    logic [31:0] r_tex;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_base;       // next even base to read
    logic [CW-1:0] r_cmp_base [2];
    logic [2:0] r_cmp_v;
    logic r_found;
    logic [7:0] r_best;
    logic [CW-1:0] r_best_base;
    logic [CW-1:0] r_out_base;
    logic r_ovf;
    logic [1:0] r_wr_idx;
    logic [23:0] r_mem0 [BD];
    logic [23:0] r_mem1 [BD];
    logic [23:0] r_mem2 [BD];
    logic [23:0] r_mem3 [BD];
    logic [23:0] r_rd [4];
    logic [7:0] w_diff [4];
    logic [7:0] w_m;
    logic [CW-1:0] w_n;

    // blend check
    logic [10:0] w_near [3], w_far [3];
    logic w_blend_ok;
    always_comb begin
        w_blend_ok = 1'b1;
        for (int k = 0; k < 3; k++) begin
            w_near[k] = 11'(3 * {3'b0, r_col[0][8*k +: 8]}) + 11'(5 * {3'b0, r_col[3][8*k +: 8]});
            w_far[k]  = 11'(5 * {3'b0, r_col[0][8*k +: 8]}) + 11'(3 * {3'b0, r_col[3][8*k +: 8]});
            if (tbpm_pkg::absdiff8(r_col[1][8*k +: 8], w_near[k][10:3]) > r_blend_tol)
                w_blend_ok = 1'b0;
            if (tbpm_pkg::absdiff8(r_col[2][8*k +: 8], w_far[k][10:3]) > r_blend_tol)
                w_blend_ok = 1'b0;
        end
    end

    assign w_n = r_four ? CW'(4) : CW'(2);
    assign pready = 1'b1;
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        case (paddr[2])
            tbpm_pkg::REG_MATCH_TOL: prdata = {24'b0, r_match_tol};
            tbpm_pkg::REG_BLEND_TOL: prdata = {24'b0, r_blend_tol};
            default: prdata = 32'b0;
        endcase
    end

    // bank reads: base is even, entries base..base+3 over four banks
    logic [AW-1:0] w_a [4];
    always_comb begin
        for (int i = 0; i < 4; i++) w_a[i] = AW'(r_base + CW'(i));
    end
    always_ff @(posedge i_clk) begin
        r_rd[0] <= w_a[0][1] ? r_mem2[w_a[0][AW-1:2]] : r_mem0[w_a[0][AW-1:2]];
        r_rd[1] <= w_a[1][1] ? r_mem3[w_a[1][AW-1:2]] : r_mem1[w_a[1][AW-1:2]];
        r_rd[2] <= w_a[2][1] ? r_mem2[w_a[2][AW-1:2]] : r_mem0[w_a[2][AW-1:2]];
        r_rd[3] <= w_a[3][1] ? r_mem3[w_a[3][AW-1:2]] : r_mem1[w_a[3][AW-1:2]];
    end

    logic [1:0] w_wsel;
    logic [CW-1:0] w_wa;
    assign w_wa = r_count + CW'(r_wr_idx);
    assign w_wsel = w_wa[1:0];
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            case (w_wsel)
                2'd0: r_mem0[w_wa[AW-1:2]] <= r_col[r_wr_idx];
                2'd1: r_mem1[w_wa[AW-1:2]] <= r_col[r_wr_idx];
                2'd2: r_mem2[w_wa[AW-1:2]] <= r_col[r_wr_idx];
                default: r_mem3[w_wa[AW-1:2]] <= r_col[r_wr_idx];
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < 4; g++) begin : g_lane
            tbpm_lane u_lane (.i_clk(i_clk), .i_entry(r_rd[g]), .i_color(r_col[g]),
                              .o_diff(w_diff[g]));
        end
    endgenerate

    // merge the lanes
    always_comb begin
        w_m = (w_diff[0] > w_diff[1]) ? w_diff[0] : w_diff[1];
        if (r_four) begin
            if (w_diff[2] > w_m) w_m = w_diff[2];
            if (w_diff[3] > w_m) w_m = w_diff[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_match_tol <= 8'd8;
            r_blend_tol <= 8'd16;
            r_count <= '0;
            r_cmp_v <= '0;
        end else begin
            if (psel && penable && pwrite && paddr[1:0] == 2'b00 && paddr[2] == tbpm_pkg::REG_MATCH_TOL)
                r_match_tol <= pwdata[7:0];
            if (psel && penable && pwrite && paddr[1:0] == 2'b00 && paddr[2] == tbpm_pkg::REG_BLEND_TOL)
                r_blend_tol <= pwdata[7:0];
            r_cmp_v <= {r_cmp_v[1:0], (r_state == S_SCAN) && (r_base + w_n <= r_count)};
            r_cmp_base[0] <= r_base;
            r_cmp_base[1] <= r_cmp_base[0];
            if (r_cmp_v[1] && (!r_found || w_m < r_best)) begin
                r_found <= 1'b1;
                r_best <= w_m;
                r_best_base <= r_cmp_base[1];
            end
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_col[0] <= i_color_zero;
                    r_col[1] <= i_color_one;
                    r_col[2] <= i_color_two;
                    r_col[3] <= i_color_three;
                    r_four <= (i_used_colors > 3'd2);
                    r_tex <= i_texel_indices;
                    r_mode <= tbpm_pkg::MODE_FOUR;
                    r_state <= S_BLEND;
                end
                S_BLEND: begin
                    if (r_four && w_blend_ok) begin
                        r_mode <= tbpm_pkg::MODE_BLEND;
                        r_four <= 1'b0;
                        r_col[1] <= r_col[3];
                        r_tex <= r_tex ^ ((r_tex & 32'h5555_5555) << 1);
                    end
                    r_base <= '0;
                    r_found <= 1'b0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_base + w_n <= r_count) r_base <= r_base + CW'(2);
                    else r_state <= S_DRAIN;
                end
                S_DRAIN: if (r_cmp_v == 3'b000) r_state <= S_DECIDE;
                S_DECIDE: begin
                    r_wr_idx <= '0;
                    r_ovf <= 1'b0;
                    if (r_found && r_best < r_match_tol) begin
                        r_out_base <= r_best_base;
                        r_state <= S_OUT;
                    end else if ({1'b0, r_count} + {1'b0, w_n} > (CW+1)'(tbpm_pkg::PALETTE_DEPTH)) begin
                        r_ovf <= 1'b1;
                        r_out_base <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_out_base <= r_count;
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (CW'(r_wr_idx) + CW'(1) == w_n) begin
                        r_count <= r_count + w_n;
                        r_state <= S_OUT;
                    end
                    r_wr_idx <= r_wr_idx + 2'd1;
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    logic [CW-2:0] w_half;
    assign w_half = r_out_base[CW-1:1];
    assign o_block_header = {r_mode, 14'(w_half)};
    assign o_texel_rows = {r_tex[7:0], r_tex[15:8], r_tex[23:16], r_tex[31:24]};
    assign o_palette_used = 16'(r_count);
    assign o_palette_overflow = r_ovf;
endmodule

// ----- hw/rtl/tbpm_checker.sv -----
`include "texel_block_palette_matcher_defines.svh"
module tbpm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_block_header,
    input logic [15:0] o_palette_used,
    input logic        o_palette_overflow
);
    `TBPM_ASSERT_IMPL(a_one_side, i_clk, i_rst_n, o_valid, !o_ready)
    `TBPM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    `TBPM_ASSERT_IMPL(a_ovf_base, i_clk, i_rst_n, o_valid && o_palette_overflow, o_block_header[13:0] == 14'd0)
    `TBPM_ASSERT_IMPL(a_used_even, i_clk, i_rst_n, o_valid, o_palette_used[0] == 1'b0)
endmodule

bind texel_block_palette_matcher tbpm_checker u_tbpm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_block_header(o_block_header),
    .o_palette_used(o_palette_used), .o_palette_overflow(o_palette_overflow)
);
